FILE: hdl/jst_pkg.sv
// Shared types and codes for the job slot table with timeout.
// Depends on nothing; imported by jst_cell, job_slot_table_with_timeout and tb.
`timescale 1ns / 1ps

package jst_pkg;

   // Request kind, carried on req_tuser
   typedef enum logic {
      OP_INJECT = 1'b0,
      OP_FETCH  = 1'b1
   } op_type;

   // Result status, carried on rsp_tuser
   typedef enum logic [2:0] {
      ST_INJECTED = 3'd0,
      ST_FULL     = 3'd1,
      ST_FETCHED  = 3'd2,
      ST_EXPIRED  = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 16;
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 16;

   // Latched request, broadcast to every cell
   typedef struct packed {
      op_type              op;
      logic [TIME_W-1:0]   now;
      logic [HANDLE_W-1:0] handle;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
   } cell_req_type;

   // Result offered by one cell; all zero when the cell does not emit
   typedef struct packed {
      logic                emit;
      logic                last;
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [ADDR_W-1:0]   addr;
      logic [SIZE_W-1:0]   size;
   } cell_out_type;

endpackage

FILE: hdl/jst_cell.sv
// One job slot of the table: stored job plus the scan token it hands to its right neighbor.
// Depends on jst_pkg.
`timescale 1ns / 1ps

module jst_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,        // scan may step this cycle
   input  logic                        shift_en,   // token register loads
   input  logic                        token_in,   // token from left neighbor
   input  jst_pkg::cell_req_type       req,
   input  logic [jst_pkg::TIME_W-1:0]  timeout,
   output logic                        token_out,  // token handed to right neighbor
   output logic                        token_here,
   output jst_pkg::cell_out_type       result
);
   import jst_pkg::*;

   logic                token_ff;
   logic                used_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [TIME_W-1:0]   start_ff;

   logic [TIME_W:0]     deadline;
   logic                expired;
   logic                hit;

   // timeout test on a 33-bit sum, strict compare
   assign deadline = {1'b0, start_ff} + {1'b0, timeout};
   assign expired  = {1'b0, req.now} > deadline;

   // inject stops at a free slot, fetch at a used one
   assign hit = token_ff && ((req.op == OP_INJECT) ? !used_ff : used_ff);

   // token moves on past a busy slot on inject, past a free or expired slot on fetch
   assign token_out  = token_ff &&
                       ((req.op == OP_INJECT) ? used_ff : (!used_ff || expired));
   assign token_here = token_ff;

   // result offered by this slot
   always_comb begin
      result = '0;
      if (hit) begin
         result.emit = 1'b1;
         if (req.op == OP_INJECT) begin
            result.status = ST_INJECTED;
            result.last   = 1'b1;
         end else if (expired) begin
            result.status = ST_EXPIRED;
            result.handle = handle_ff;
         end else begin
            result.status = ST_FETCHED;
            result.last   = 1'b1;
            result.handle = handle_ff;
            result.addr   = addr_ff;
            result.size   = size_ff;
         end
      end
   end

   // token and used mark
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= 1'b0;
         used_ff  <= 1'b0;
      end else begin
         if (shift_en) begin
            token_ff <= token_in;
         end
         if (adv && hit) begin
            used_ff <= (req.op == OP_INJECT);
         end
      end
   end

   // job payload, written on inject
   always_ff @(posedge clock) begin
      if (adv && hit && (req.op == OP_INJECT)) begin
         handle_ff <= req.handle;
         addr_ff   <= req.addr;
         size_ff   <= req.size;
         start_ff  <= req.now;
      end
   end

endmodule

FILE: hdl/job_slot_table_with_timeout.sv
// Top level of the job slot table: request latch, row of jst_cell slots, result register.
// Depends on jst_pkg and jst_cell.
// Scan: token enters slot 0 at the accepting edge, moves one slot per cycle while not stalled;
// a slot's result is registered, full or empty comes from the tail stage past the last slot.
// Expired results ride along the scan; a held result with rsp_tready low stalls it.
// Throughput: one request at a time, next taken after the final result. Reset frees all.
`timescale 1ns / 1ps

module job_slot_table_with_timeout #(
   parameter int SLOTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // current_time[31:0], job_handle[47:32],
                                     // buf_addr[79:48], buffer_size[95:80]
   input  logic [0:0]   req_tuser,   // req_type[0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // out_handle[15:0], out_addr[47:16], out_size[63:48]
   output logic [2:0]   rsp_tuser,   // status[2:0]
   output logic         rsp_tlast,
   // configuration
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data  // timeout_limit
);
   import jst_pkg::*;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30;

   logic                busy_ff, busy_in;
   cell_req_type        req_ff;
   logic [TIME_W-1:0]   timeout_ff;

   logic                rsp_valid_ff;
   cell_out_type        rsp_ff;
   logic                tail_ff;

   logic                start;
   logic                adv;
   logic                shift_en;
   logic [SLOTS-1:0]    token_pass;
   logic [SLOTS-1:0]    token_vec;
   logic [SLOTS-1:0]    emit_vec;
   cell_out_type        cell_res [SLOTS];
   cell_out_type        hit;

   assign start      = req_tvalid && req_tready;
   assign adv        = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign shift_en   = adv || start;
   assign req_tready = !busy_ff;

   // request latch
   always_ff @(posedge clock) begin
      if (start) begin
         req_ff.op     <= op_type'(req_tuser[0]);
         req_ff.now    <= req_tdata[31:0];
         req_ff.handle <= req_tdata[47:32];
         req_ff.addr   <= req_tdata[79:48];
         req_ff.size   <= req_tdata[95:80];
      end
   end

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // row of slots
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      logic tin;
      if (i == 0) begin : g_first
         assign tin = start;
      end else begin : g_next
         assign tin = token_pass[i-1];
      end
      jst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .shift_en   (shift_en),
         .token_in   (tin),
         .req        (req_ff),
         .timeout    (timeout_ff),
         .token_out  (token_pass[i]),
         .token_here (token_vec[i]),
         .result     (cell_res[i])
      );
      assign emit_vec[i] = cell_res[i].emit;
   end

   // stage past the last slot: token arriving here answers full or empty
   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= 1'b0;
      end else if (shift_en) begin
         tail_ff <= token_pass[SLOTS-1];
      end
   end

   // one-hot select of the emitting slot or the tail stage
   always_comb begin
      hit = '0;
      for (int i = 0; i < SLOTS; i++) begin
         hit = cell_out_type'(hit | cell_res[i]);
      end
      if (tail_ff) begin
         hit.emit   = 1'b1;
         hit.last   = 1'b1;
         hit.status = (req_ff.op == OP_INJECT) ? ST_FULL : ST_EMPTY;
      end
   end

   // busy flag next value
   always_comb begin
      busy_in = busy_ff;
      if (start) begin
         busy_in = 1'b1;
      end else if (adv && hit.emit && hit.last) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && hit.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && hit.emit) begin
         rsp_ff <= hit;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.size, rsp_ff.addr, rsp_ff.handle};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

   // checks
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one slot holds the scan token");

   a_idle_no_token: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ((token_vec == '0) && !tail_ff))
      else $error("scan token present while idle");

   a_single_emitter: assert property (@(posedge clock) disable iff (reset)
      $onehot0({tail_ff, emit_vec}))
      else $error("several results offered in one cycle");

   a_last_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (adv && hit.emit && hit.last) |=> (!busy_ff && (token_vec == '0)))
      else $error("scan still running after final result");

   a_start_token: assert property (@(posedge clock) disable iff (reset)
      start |=> token_vec[0])
      else $error("accepted request did not place token in slot 0");

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for job_slot_table_with_timeout: directed and random requests,
// results compared against an in-bench mirror of the slot table. Depends on jst_pkg and job_slot_table_with_timeout.
`timescale 1ns / 1ps

module tb;
   import jst_pkg::*;

   localparam int TABLE_SLOTS = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 80;
   localparam logic [31:0] TIMEOUT_AT_RESET = 32'd30;

   // One expected answer of the table
   typedef struct {
      status_type  status;
      logic [15:0] handle;
      logic [31:0] addr;
      logic [15:0] size;
      logic        last;
   } table_answer_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_wr_en = 1'b0;
   logic [31:0]  csr_wr_data = '0;

   // Mirror of the slot table and its timeout register
   logic        slot_busy [TABLE_SLOTS];
   logic [15:0] slot_job_handle [TABLE_SLOTS];
   logic [31:0] slot_job_addr [TABLE_SLOTS];
   logic [15:0] slot_job_size [TABLE_SLOTS];
   logic [31:0] slot_stamp [TABLE_SLOTS];
   logic [31:0] job_timeout;

   table_answer_type due_answers[$];
   int fail_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic [31:0] clock_now;

   job_slot_table_with_timeout #(.SLOTS(TABLE_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** job_slot_table_with_timeout: FAILED **");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Work out the answers one request causes and update the mirror
   function automatic void table_answer(op_type op, logic [31:0] now, logic [15:0] handle,
                                        logic [31:0] addr, logic [15:0] size);
      table_answer_type ans;
      logic [32:0] deadline;
      ans.status = ST_FULL;
      ans.handle = '0;
      ans.addr   = '0;
      ans.size   = '0;
      ans.last   = 1'b1;
      if (op == OP_INJECT) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (!slot_busy[i]) begin
               slot_busy[i]       = 1'b1;
               slot_job_handle[i] = handle;
               slot_job_addr[i]   = addr;
               slot_job_size[i]   = size;
               slot_stamp[i]      = now;
               ans.status         = ST_INJECTED;
               break;
            end
         end
         due_answers = {due_answers, ans};
         return;
      end
      // fetch: drop stale jobs from the low end, hand out the first live one
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_busy[i]) begin
            slot_busy[i] = 1'b0;
            deadline = {1'b0, slot_stamp[i]} + {1'b0, job_timeout};
            ans.handle = slot_job_handle[i];
            if ({1'b0, now} > deadline) begin
               ans.status = ST_EXPIRED;
               ans.last   = 1'b0;
               due_answers = {due_answers, ans};
            end else begin
               ans.status = ST_FETCHED;
               ans.addr   = slot_job_addr[i];
               ans.size   = slot_job_size[i];
               ans.last   = 1'b1;
               due_answers = {due_answers, ans};
               return;
            end
         end
      end
      ans.status = ST_EMPTY;
      ans.handle = '0;
      ans.last   = 1'b1;
      due_answers = {due_answers, ans};
   endfunction

   // Compare each accepted result with the oldest expected answer
   always @(posedge clock) begin
      table_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_answers.size() == 0) begin
            $error("unexpected result: status %0d handle %h", rsp_tuser, rsp_tdata[15:0]);
            fail_count++;
         end else begin
            want = due_answers.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[15:0] !== want.handle) begin
               $error("out_handle: expected %h, got %h", want.handle, rsp_tdata[15:0]);
               fail_count++;
            end
            if (rsp_tdata[47:16] !== want.addr) begin
               $error("out_addr: expected %h, got %h", want.addr, rsp_tdata[47:16]);
               fail_count++;
            end
            if (rsp_tdata[63:48] !== want.size) begin
               $error("out_size: expected %h, got %h", want.size, rsp_tdata[63:48]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %b, got %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Send one request; returns at the edge where it was accepted
   task automatic send_request(op_type op, logic [31:0] now, logic [15:0] handle,
                               logic [31:0] addr, logic [15:0] size);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {size, addr, handle, now};
      do @(posedge clock); while (!req_tready);
      table_answer(op, now, handle, addr, size);
   endtask

   task automatic inject_job(logic [31:0] now, logic [15:0] handle, logic [31:0] addr,
                             logic [15:0] size);
      send_request(OP_INJECT, now, handle, addr, size);
   endtask

   task automatic fetch_job(logic [31:0] now);
      send_request(OP_FETCH, now, 16'($urandom), $urandom, 16'($urandom));
   endtask

   // Let the table drain and settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
      repeat (TABLE_SLOTS + 4) @(posedge clock);
   endtask

   // Only called while the table is idle
   task automatic write_timeout(logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      job_timeout = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
         default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
   endtask

   // Fetch on a table that was never written
   task automatic test_empty_table();
      fetch_job(32'd0);
   endtask

   // Field extremes, table filled up, one inject past full
   task automatic test_fill_extremes();
      inject_job(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      inject_job(32'd0, 16'h0000, 32'h0000_0000, 16'h0000);
      for (int i = 2; i < TABLE_SLOTS; i++)
         inject_job(32'd1000, 16'($urandom), $urandom, 16'($urandom));
      inject_job(32'd1000, 16'($urandom), $urandom, 16'($urandom));
   endtask

   // Time running backward, exactly at the deadline, one past it
   task automatic test_deadline_edges();
      fetch_job(32'd30);
      fetch_job(32'd30);
      fetch_job(32'd1031);
   endtask

   // Largest and zero timeout; deadline sum must not wrap
   task automatic test_timeout_extremes();
      wait_idle();
      write_timeout(32'hFFFF_FFFF);
      inject_job(32'hFFFF_FFFF, 16'($urandom), $urandom, 16'($urandom));
      inject_job(32'd1, 16'($urandom), $urandom, 16'($urandom));
      fetch_job(32'd0);
      fetch_job(32'hFFFF_FFFF);
      wait_idle();
      write_timeout(32'd0);
      inject_job(32'd5, 16'($urandom), $urandom, 16'($urandom));
      fetch_job(32'd5);
      inject_job(32'd5, 16'($urandom), $urandom, 16'($urandom));
      fetch_job(32'd6);
   endtask

   // Bursts of mixed traffic under changing timeouts and idling
   task automatic test_random_traffic();
      int sent;
      int burst_len;
      int step_max;
      logic [31:0] tmo;
      sent = 0;
      while (sent < RANDOM_REQUESTS) begin
         wait_idle();
         set_idling((sent * 4) / RANDOM_REQUESTS);
         if ($urandom_range(3) == 0) begin
            // fill the table close in time, then fetch long after: a flood of expiries
            tmo = $urandom_range(0, 20);
            write_timeout(tmo);
            clock_now = $urandom_range(0, 32'h7FFF_FFFF);
            for (int i = 0; i <= TABLE_SLOTS; i++) begin
               inject_job(clock_now, 16'($urandom), $urandom, 16'($urandom));
               clock_now += $urandom_range(0, 1);
            end
            fetch_job(clock_now + tmo + $urandom_range(20, 100));
            sent += TABLE_SLOTS + 2;
         end else begin
            case ($urandom_range(5))
               0: tmo = 32'd0;
               1: tmo = $urandom_range(1, 20);
               2: tmo = TIMEOUT_AT_RESET;
               3: tmo = 32'hFFFF_FFFF;
               4: tmo = $urandom;
               default: tmo = $urandom_range(100, 1000);
            endcase
            write_timeout(tmo);
            step_max = (tmo < 40) ? 2 * tmo + 2 : 80;
            clock_now = $urandom;
            burst_len = $urandom_range(8, 16);
            for (int i = 0; i < burst_len; i++) begin
               case ($urandom_range(11))
                  0: clock_now = $urandom;
                  1: clock_now -= $urandom_range(1, 50);
                  default: clock_now += $urandom_range(0, step_max);
               endcase
               if ($urandom_range(99) < 55)
                  inject_job(clock_now, 16'($urandom), $urandom, 16'($urandom));
               else
                  fetch_job(clock_now);
            end
            sent += burst_len;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_busy[i]       = 1'b0;
         slot_job_handle[i] = '0;
         slot_job_addr[i]   = '0;
         slot_job_size[i]   = '0;
         slot_stamp[i]      = '0;
      end
      job_timeout = TIMEOUT_AT_RESET;
      set_idling(0);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_table();
      test_fill_extremes();
      test_deadline_edges();
      test_timeout_extremes();
      test_random_traffic();
      wait_idle();

      if (fail_count == 0)
         $display("** job_slot_table_with_timeout: PASSED **");
      else
         $display("** job_slot_table_with_timeout: FAILED **");
      $finish;
   end

endmodule

FILE: job_slot_table_with_timeout.f
hdl/jst_pkg.sv
hdl/jst_cell.sv
hdl/job_slot_table_with_timeout.sv
tb/sv/tb.sv
